// ===== sv/bpa_pkg.sv =====
// Shared types and constants for the next-fit bitmap page allocator.
// No dependencies; imported by bpa_word_scan and the top level.
package bpa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int WORD_IDX_W = 5;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OOM          = 3'd1,
    ST_MISALIGNED   = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [27:0] page_address;
    logic [16:0] free_count;
  } out_item_t;

  // Window limits for one bitmap word.
  typedef struct packed {
    logic                  lo_en;
    logic [WORD_IDX_W-1:0] lo_bit;
    logic                  hi_en;
    logic [WORD_IDX_W-1:0] hi_bit;
  } scan_win_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] bit_idx;
  } scan_res_t;

endpackage

// ===== sv/bpa_word_scan.sv =====
// Find-first-free search over one 32-bit word of the used map, limited to a window.
// Depends on bpa_pkg.
module bpa_word_scan
  import bpa_pkg::*;
(
  input  logic [WORD_BITS-1:0] used_i,
  input  scan_win_t            win_i,
  output scan_res_t            res_o
);

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;

  always_comb begin
    lo_mask = win_i.lo_en ? ({WORD_BITS{1'b1}} << win_i.lo_bit) : {WORD_BITS{1'b1}};
    // keep bits at or below hi_bit
    hi_mask = win_i.hi_en ? ~({{(WORD_BITS-1){1'b1}}, 1'b0} << win_i.hi_bit)
                          : {WORD_BITS{1'b1}};
    cand    = ~used_i & lo_mask & hi_mask;
  end

  always_comb begin
    res_o.found   = |cand;
    res_o.bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.bit_idx = WORD_IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/bitmap_page_allocator_next_fit_core.sv =====
// Top level of the next-fit bitmap page allocator: used-map memory, sequencer, counters.
// Depends on bpa_pkg and bpa_word_scan.
//
//  channel  signals                        dir  payload
//  in       in_valid_i / in_ready_o        in   in_item_t  (action, address)
//  out      out_valid_o / out_ready_i      out  out_item_t (status, page_address, free_count)
//  cfg      cfg_valid_i / cfg_ready_o      in   total_pages, 17 bit
//
// One request at a time. A free steps through accept, map read, check and write, result;
// a misaligned or out-of-range free skips the map and goes from accept straight to result.
// An allocate gives each 32-page map word that it scans a registered read and then one pass
// through the shared word scanner.
// After reset the map is set to all used by a sweep of one word a cycle with in_ready_o low;
// cfg writes are taken at any time.
// A result waiting on out_ready_i holds the sequencer before it returns to idle.
module bitmap_page_allocator_next_fit_core
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  localparam int PB        = $clog2(PAGE_BYTES);
  localparam int WORDS_RAW = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORDS     = (WORDS_RAW < 2) ? 2 : WORDS_RAW;
  localparam int WAW       = $clog2(WORDS);
  localparam int PIW       = WAW + WORD_IDX_W;
  localparam int CW        = ((PIW > 17) ? PIW : 17) + 1;

  state_e               state_q, state_d;
  logic [WAW-1:0]       word_q, word_d;
  logic                 phase_q, phase_d;
  logic                 is_free_q, is_free_d;
  logic [PIW-1:0]       page_q, page_d;
  logic [PIW-1:0]       hint_q, hint_d;
  logic [16:0]          free_q, free_d;
  logic [16:0]          total_q;
  out_item_t            res_q, res_d;
  out_item_t            out_q;
  logic                 out_valid_q;
  logic                 out_load;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_we;
  logic [WAW-1:0]       mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  logic [CW-1:0]        tot_eff;
  logic [CW-1:0]        hint_w;
  logic [CW-1:0]        wrap_end;
  logic [CW-1:0]        lo_w;
  logic [CW-1:0]        hi_w;
  logic [CW-1:0]        hi_m1;
  logic [CW-1:0]        cur_w;
  logic [31:0]          page_in;
  logic [PIW-1:0]       found_page;
  logic [PIW+PB-1:0]    pa_wide;
  scan_win_t            win;
  scan_res_t            scan;

  assign tot_eff  = (CW'(total_q) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(total_q);
  assign hint_w   = CW'(hint_q);
  assign wrap_end = (hint_w < tot_eff) ? hint_w : tot_eff;
  assign page_in  = in_data_i.address >> PB;

  // search window for the current pass: [hint, total) then [0, min(hint, total))
  assign lo_w  = phase_q ? '0 : hint_w;
  assign hi_w  = phase_q ? wrap_end : tot_eff;
  assign hi_m1 = hi_w - CW'(1);
  assign cur_w = CW'(word_q);

  assign win.lo_en  = (cur_w == (lo_w >> WORD_IDX_W));
  assign win.lo_bit = lo_w[WORD_IDX_W-1:0];
  assign win.hi_en  = (cur_w == (hi_m1 >> WORD_IDX_W));
  assign win.hi_bit = hi_m1[WORD_IDX_W-1:0];

  bpa_word_scan u_scan (
    .used_i (rd_data_q),
    .win_i  (win),
    .res_o  (scan)
  );

  assign found_page = {word_q, scan.bit_idx};
  assign pa_wide    = {found_page, {PB{1'b0}}};

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    phase_d   = phase_q;
    is_free_d = is_free_q;
    page_d    = page_q;
    hint_d    = hint_q;
    free_d    = free_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wa    = word_q;
    mem_wd    = rd_data_q;

    unique case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = {WORD_BITS{1'b1}};
        word_d = word_q + WAW'(1);
        if (word_q == WAW'(WORDS - 1)) begin
          word_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.status       = ST_OK;
          res_d.page_address = '0;
          res_d.free_count   = free_q;
          is_free_d          = (in_data_i.action == ACT_FREE);
          if (in_data_i.action == ACT_FREE) begin
            page_d = PIW'(page_in);
            word_d = WAW'(page_in >> WORD_IDX_W);
            if (in_data_i.address[PB-1:0] != '0) begin
              res_d.status = ST_MISALIGNED;
              state_d      = S_DONE;
            end else if (page_in >= 32'(tot_eff)) begin
              res_d.status = ST_OUT_OF_RANGE;
              state_d      = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end else if (hint_w < tot_eff) begin
            phase_d = 1'b0;
            word_d  = hint_q[PIW-1:WORD_IDX_W];
            state_d = S_RD;
          end else if (wrap_end != '0) begin
            phase_d = 1'b1;
            word_d  = '0;
            state_d = S_RD;
          end else begin
            res_d.status = ST_OOM;
            state_d      = S_DONE;
          end
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        if (is_free_q) begin
          if (!rd_data_q[page_q[WORD_IDX_W-1:0]]) begin
            res_d.status = ST_ALREADY_FREE;
          end else begin
            mem_we = 1'b1;
            mem_wd = rd_data_q & ~(WORD_BITS'(1) << page_q[WORD_IDX_W-1:0]);
            free_d = free_q + 17'd1;
            res_d.free_count = free_q + 17'd1;
            if (page_q < hint_q) begin
              hint_d = page_q;
            end
          end
          state_d = S_DONE;
        end else if (scan.found) begin
          mem_we = 1'b1;
          mem_wd = rd_data_q | (WORD_BITS'(1) << scan.bit_idx);
          free_d = free_q - 17'd1;
          hint_d = found_page;
          res_d.free_count   = free_q - 17'd1;
          res_d.page_address = 28'(pa_wide);
          state_d = S_DONE;
        end else if (win.hi_en) begin
          // end of this pass
          if (!phase_q && (wrap_end != '0)) begin
            phase_d = 1'b1;
            word_d  = '0;
            state_d = S_RD;
          end else begin
            res_d.status = ST_OOM;
            state_d      = S_DONE;
          end
        end else begin
          word_d  = word_q + WAW'(1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      word_q      <= '0;
      phase_q     <= 1'b0;
      is_free_q   <= 1'b0;
      hint_q      <= '0;
      free_q      <= '0;
      total_q     <= 17'h10000;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      word_q    <= word_d;
      phase_q   <= phase_d;
      is_free_q <= is_free_d;
      hint_q    <= hint_d;
      free_q    <= free_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // used map, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[word_q];
  end

endmodule

// ===== tb/tb_bitmap_page_allocator_next_fit_core.sv =====
// Testbench for bitmap_page_allocator_next_fit_core: directed and random alloc/free beats,
// checked field by field against a next-fit page map kept inside a small scoreboard class.
// Depends on bpa_pkg and the RTL top level only.
module tb_bitmap_page_allocator_next_fit_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int PAGES          = 65536;
  localparam int PAGE_BYTES     = 4096;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_PHASES       = 14;

  class page_alloc_scoreboard;
    bit          used_map [PAGES];
    logic [16:0] free_pages;
    logic [15:0] search_hint;
    logic [16:0] total_pages;
    out_item_t   awaited_results [$];
    int          errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b1;
      free_pages  = '0;
      search_hint = '0;
      total_pages = 17'(PAGES);
      errors      = 0;
    endfunction

    function void write_total(logic [16:0] v);
      total_pages = v;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_request(in_item_t req);
      int unsigned eff;
      int unsigned wrap_end;
      int unsigned page;
      int unsigned hit;
      bit          found;
      out_item_t   res;
      eff              = (total_pages > PAGES) ? PAGES : total_pages;
      res.status       = ST_OK;
      res.page_address = '0;
      found            = 1'b0;
      hit              = 0;
      if (req.action == ACT_ALLOC) begin
        // next fit: hint up to the top, then wrap from 0 up to the hint
        wrap_end = (search_hint < eff) ? search_hint : eff;
        for (page = search_hint; page < eff && !found; page++)
          if (!used_map[page]) begin
            found = 1'b1;
            hit   = page;
          end
        for (page = 0; page < wrap_end && !found; page++)
          if (!used_map[page]) begin
            found = 1'b1;
            hit   = page;
          end
        if (found) begin
          used_map[hit]    = 1'b1;
          free_pages       = free_pages - 1;
          search_hint      = 16'(hit);
          res.page_address = 28'(hit * PAGE_BYTES);
        end else begin
          res.status = ST_OOM;
        end
      end else begin
        page = req.address / PAGE_BYTES;
        if (req.address % PAGE_BYTES != 0) begin
          res.status = ST_MISALIGNED;
        end else if (page >= eff) begin
          res.status = ST_OUT_OF_RANGE;
        end else if (!used_map[page]) begin
          res.status = ST_ALREADY_FREE;
        end else begin
          used_map[page] = 1'b0;
          free_pages     = free_pages + 1;
          if (page < search_hint) search_hint = 16'(page);
        end
      end
      res.free_count = free_pages;
      awaited_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0d page_address 0x%0h free_count %0d",
               got.status, got.page_address, got.free_count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.page_address !== want.page_address) begin
        $error("page_address: expected 0x%0h, actual 0x%0h", want.page_address,
               got.page_address);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [16:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_ready;

  bit gaps_on      = 1'b1;
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  page_alloc_scoreboard sb = new();

  always #4 clk = ~clk;

  bitmap_page_allocator_next_fit_core #(
    .MAX_PAGES (PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.write_total(cfg_data);
      if (in_valid && in_ready) sb.note_request(in_data);
      if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold         = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_request(logic act, logic [31:0] addr);
    in_item_t req;
    req.action  = act;
    req.address = addr;
    return req;
  endfunction

  function automatic in_item_t random_request(int unsigned eff);
    in_item_t    req;
    int unsigned kind;
    kind        = $urandom_range(0, 19);
    req.action  = (kind < 9) ? ACT_ALLOC : ACT_FREE;
    req.address = $urandom();
    if (kind >= 9 && kind <= 15) begin
      req.address = {20'($urandom_range(0, eff - 1)), 12'h000};
    end else if (kind == 16) begin
      if (req.address[11:0] == 12'h000) req.address[0] = 1'b1;
    end else if (kind == 17) begin
      req.address = {20'($urandom_range(eff, 20'hFFFFF)), 12'h000};
    end else if (kind == 19) begin
      // top managed page or the first one past it
      req.address = {20'(eff - 1 + $urandom_range(0, 1)), 12'h000};
    end
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_total(logic [16:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [16:0] phase_total [N_PHASES];
    int unsigned eff;
    int          n_items;

    phase_total = '{17'd64, 17'd8, 17'd200, 17'd1, 17'd37,
                    17'd65536, 17'd100, 17'd32, 17'h1FFFF,
                    17'd150, 17'd33, 17'd2, 17'd256, 17'd96};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default size, every page used after reset
    send_request(make_request(ACT_ALLOC, 32'hFFFF_FFFF));
    send_request(make_request(ACT_FREE, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h0000_0001));
    send_request(make_request(ACT_FREE, 32'h0000_0FFF));
    send_request(make_request(ACT_FREE, 32'h0FFF_F000));
    send_request(make_request(ACT_FREE, 32'h1000_0000));
    send_request(make_request(ACT_FREE, 32'hFFFF_F000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h0006_4000));
    send_request(make_request(ACT_FREE, 32'h0000_5000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h8000_0800));

    // nothing managed
    write_total(17'd0);
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h0000_0000));

    // oversized count saturates
    write_total(17'h1FFFF);
    send_request(make_request(ACT_FREE, 32'h0FFF_F000));
    send_request(make_request(ACT_ALLOC, 32'h1234_5678));

    // one page, hint left far above the top
    write_total(17'd1);
    send_request(make_request(ACT_FREE, 32'h0000_0000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_ALLOC, 32'h0000_0000));
    send_request(make_request(ACT_FREE, 32'h0000_1000));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      gaps_on = (ph != N_PHASES - 1);
      write_total(phase_total[ph]);
      eff     = (phase_total[ph] > PAGES) ? PAGES : phase_total[ph];
      // large maps make allocs scan thousands of words, keep those phases short
      n_items = (eff >= 4096) ? 30 : 150;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 2 && i == 60) hold_pending = 1'b1;
        send_request(random_request(eff));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
